// ===== hdl/alrulfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alrulfu_pkg
// Shared sizes, codes and item types of the adaptive LRU/LFU replacement unit.
// ----------------------------------------------------------------------------
package alrulfu_pkg;

	localparam int CAPACITY    = 64;
	localparam int FREQ_LEVELS = 16;
	localparam int RES_SLOTS   = CAPACITY + 1;
	localparam int GHOST_SLOTS = CAPACITY;

	localparam int RES_AW   = $clog2(RES_SLOTS);
	localparam int GHOST_AW = $clog2(GHOST_SLOTS);
	localparam int RANK_W   = $clog2(RES_SLOTS);
	localparam int GSTAMP_W = $clog2(GHOST_SLOTS);
	localparam int FREQ_W   = $clog2(FREQ_LEVELS + 1);
	localparam int CNT_W    = $clog2(RES_SLOTS + 1);
	localparam int CAP_W    = 7;
	localparam int PAGE_W   = 32;
	localparam int BAL_W    = 16;

	typedef enum logic [2:0] {
		OUT_HIT       = 3'd0,
		OUT_GHOST_LRU = 3'd1,
		OUT_GHOST_LFU = 3'd2,
		OUT_MISS      = 3'd3,
		OUT_WRITE     = 3'd4
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_UPDATE,
		ST_UPD_END,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic              mode;
		logic [PAGE_W-1:0] page;
	} acc_req_t;

	typedef struct packed {
		outcome_t          outcome;
		logic              evict_valid;
		logic [PAGE_W-1:0] evict_page;
		logic              evict_by_lfu;
		logic              drop_valid;
		logic [PAGE_W-1:0] drop_page;
	} acc_rsp_t;

	typedef struct packed {
		logic [PAGE_W-1:0] tag;
		logic [FREQ_W-1:0] freq;
		logic [RANK_W-1:0] rec;
		logic [RANK_W-1:0] bkt;
	} res_ent_t;

	typedef struct packed {
		logic [PAGE_W-1:0]   tag;
		logic                lfu;
		logic [GSTAMP_W-1:0] stamp;
	} ghost_ent_t;

endpackage

// ===== hdl/adaptive_lru_lfu_replacement_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_lru_lfu_replacement_unit
// Page replacement with LRU/LFU victim choice steered by ghost-list hits.
// ----------------------------------------------------------------------------
// channel  | signals                   | handshake
// ---------+---------------------------+-------------------------------
// access   | start, busy, req          | taken when start & !busy
// result   | rsp_valid, rsp            | one-cycle strobe, no back-pressure
// config   | cfg_valid, cfg_ready, cfg_data | written when valid & ready
//
// A read item runs as a pass of 65 reads over the resident and
// ghost memories to find hits, counts and victims, a decision step, and a
// read-modify-write pass of 65 entries that re-ranks both stores, then commit.
// Each pass reads each memory through its single read port.
// A write item is answered in the next cycle. busy is high while a read is in
// work. Reset empties both stores at once through their valid flops.
// ----------------------------------------------------------------------------
module adaptive_lru_lfu_replacement_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  alrulfu_pkg::acc_req_t                 req,
	output logic                                  rsp_valid,
	output alrulfu_pkg::acc_rsp_t                 rsp,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [alrulfu_pkg::CAP_W-1:0]         cfg_data
);

	localparam logic [alrulfu_pkg::BAL_W-1:0] BAL_MAX = {1'b0, {(alrulfu_pkg::BAL_W-1){1'b1}}};
	localparam logic [alrulfu_pkg::BAL_W-1:0] BAL_MIN = {1'b1, {(alrulfu_pkg::BAL_W-1){1'b0}}};

	alrulfu_pkg::state_t state_q, state_d;

	alrulfu_pkg::res_ent_t   res_mem [alrulfu_pkg::RES_SLOTS];
	alrulfu_pkg::ghost_ent_t ghost_mem [alrulfu_pkg::GHOST_SLOTS];
	alrulfu_pkg::res_ent_t   res_rd_q, res_wdata;
	alrulfu_pkg::ghost_ent_t ghost_rd_q, ghost_wdata;
	logic                                res_we, ghost_we;
	logic [alrulfu_pkg::RES_AW-1:0]      res_waddr;
	logic [alrulfu_pkg::GHOST_AW-1:0]    ghost_waddr;

	logic [alrulfu_pkg::RES_SLOTS-1:0]   res_valid_q;
	logic [alrulfu_pkg::GHOST_SLOTS-1:0] ghost_valid_q;

	logic [alrulfu_pkg::CAP_W-1:0]  cap_q;
	logic [alrulfu_pkg::BAL_W-1:0]  bal_q;
	logic [alrulfu_pkg::PAGE_W-1:0] page_q;
	logic [alrulfu_pkg::RES_AW-1:0] addr_q;

	logic                           vld_s1, pass_s1;
	logic [alrulfu_pkg::RES_AW-1:0] idx_s1;

	// scan results
	logic                             hit_found_q, gh_found_q, rfree_found_q, gfree_found_q;
	logic [alrulfu_pkg::RES_AW-1:0]   hit_idx_q, rfree_idx_q, lru_idx_q, lfu_idx_q;
	logic [alrulfu_pkg::GHOST_AW-1:0] gh_idx_q, gfree_idx_q;
	alrulfu_pkg::res_ent_t            hit_ent_q, lru_ent_q, lfu_ent_q;
	alrulfu_pkg::ghost_ent_t          gh_ent_q;
	logic [alrulfu_pkg::CNT_W-1:0]    rcount_q, gcount_q;

	// decisions
	logic                               res_hit_q, gh_hit_q, evict_q, by_lfu_q;
	logic                               rm_valid_q, new_write_q, drop_q, drop_self_q, app_q;
	logic [alrulfu_pkg::RES_AW-1:0]     rm_idx_q, new_slot_q;
	alrulfu_pkg::res_ent_t              rm_ent_q;
	logic [alrulfu_pkg::FREQ_W-1:0]     f_tgt_q;
	logic [alrulfu_pkg::RANK_W-1:0]     new_rec_q, nt_q;
	logic [alrulfu_pkg::PAGE_W-1:0]     evict_page_q, drop_page_q;
	logic [alrulfu_pkg::GSTAMP_W-1:0]   app_stamp_q;

	logic                      rsp_valid_q;
	alrulfu_pkg::acc_rsp_t     rsp_q;

	logic accept;

	// decision logic
	logic [alrulfu_pkg::CNT_W-1:0]    cap_eff;
	logic                             d_res_hit, d_gh_hit, d_evict, d_by_lfu, d_victim_new;
	logic                             d_rm_valid, d_drop, d_drop_self;
	logic [alrulfu_pkg::BAL_W-1:0]    d_bal;
	alrulfu_pkg::res_ent_t            d_vent, d_rm_ent;
	logic [alrulfu_pkg::RES_AW-1:0]   d_vidx, d_rm_idx;
	logic [alrulfu_pkg::FREQ_W-1:0]   d_ftgt;
	logic [alrulfu_pkg::CNT_W-1:0]    d_gc_rem;
	logic [alrulfu_pkg::PAGE_W-1:0]   d_evict_page;

	// update pass logic
	logic                             u_rv, u_is_rm, u_gok, u_gv, u_is_grm, u_dropping, u_cnt;
	logic [alrulfu_pkg::GHOST_AW-1:0] u_gidx;
	logic [alrulfu_pkg::GSTAMP_W-1:0] u_adj;
	alrulfu_pkg::res_ent_t            u_rent;
	alrulfu_pkg::ghost_ent_t          u_gent;

	// scan step logic
	logic s_scan, s_rv, s_gv;

	assign accept    = start && !busy;
	assign busy      = (state_q != alrulfu_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alrulfu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			alrulfu_pkg::ST_IDLE: begin
				if (accept && !req.mode) state_d = alrulfu_pkg::ST_SCAN;
			end
			alrulfu_pkg::ST_SCAN: begin
				if (addr_q == alrulfu_pkg::RES_AW'(alrulfu_pkg::RES_SLOTS - 1))
					state_d = alrulfu_pkg::ST_SCAN_END;
			end
			alrulfu_pkg::ST_SCAN_END: state_d = alrulfu_pkg::ST_DECIDE;
			alrulfu_pkg::ST_DECIDE:   state_d = alrulfu_pkg::ST_UPDATE;
			alrulfu_pkg::ST_UPDATE: begin
				if (addr_q == alrulfu_pkg::RES_AW'(alrulfu_pkg::RES_SLOTS - 1))
					state_d = alrulfu_pkg::ST_UPD_END;
			end
			alrulfu_pkg::ST_UPD_END: state_d = alrulfu_pkg::ST_COMMIT;
			alrulfu_pkg::ST_COMMIT:  state_d = alrulfu_pkg::ST_IDLE;
			default:                 state_d = alrulfu_pkg::ST_IDLE;
		endcase
	end

	// ---------------- decision ----------------
	always_comb begin
		if (cap_q == '0)
			cap_eff = alrulfu_pkg::CNT_W'(1);
		else if (int'(cap_q) > alrulfu_pkg::CAPACITY)
			cap_eff = alrulfu_pkg::CNT_W'(alrulfu_pkg::CAPACITY);
		else
			cap_eff = alrulfu_pkg::CNT_W'(cap_q);

		d_res_hit = hit_found_q;
		d_gh_hit  = !hit_found_q && gh_found_q;

		d_bal = bal_q;
		if (d_gh_hit) begin
			if (gh_ent_q.lfu) begin
				if (bal_q != BAL_MAX) d_bal = bal_q + 1'b1;
			end else begin
				if (bal_q != BAL_MIN) d_bal = bal_q - 1'b1;
			end
		end
		d_by_lfu = d_bal[alrulfu_pkg::BAL_W-1];

		if (d_res_hit)
			d_evict = 1'b0;
		else if (d_gh_hit)
			d_evict = (rcount_q + 1'b1) >= cap_eff;
		else
			d_evict = rcount_q >= cap_eff;

		// after a ghost hit the reinserted page itself may be the victim
		d_victim_new = d_gh_hit && ((rcount_q == '0) ||
			(d_by_lfu && (lfu_ent_q.freq != alrulfu_pkg::FREQ_W'(1))));

		d_vent = d_by_lfu ? lfu_ent_q : lru_ent_q;
		d_vidx = d_by_lfu ? lfu_idx_q : lru_idx_q;

		if (d_res_hit) begin
			d_rm_valid = 1'b1;
			d_rm_idx   = hit_idx_q;
			d_rm_ent   = hit_ent_q;
		end else begin
			d_rm_valid = d_evict && !d_victim_new;
			d_rm_idx   = d_vidx;
			d_rm_ent   = d_vent;
		end

		if (d_res_hit && (hit_ent_q.freq < alrulfu_pkg::FREQ_W'(alrulfu_pkg::FREQ_LEVELS)))
			d_ftgt = hit_ent_q.freq + 1'b1;
		else if (d_res_hit)
			d_ftgt = hit_ent_q.freq;
		else
			d_ftgt = alrulfu_pkg::FREQ_W'(1);

		d_evict_page = d_victim_new ? page_q : d_vent.tag;
		d_gc_rem     = gcount_q - alrulfu_pkg::CNT_W'(d_gh_hit);
		d_drop       = d_evict && ((d_gc_rem + 1'b1) >= cap_eff);
		d_drop_self  = d_drop && (d_gc_rem == '0);
	end

	// ---------------- per-entry logic ----------------
	always_comb begin
		s_scan = vld_s1 && !pass_s1;
		s_rv   = res_valid_q[idx_s1];
		u_gok  = int'(idx_s1) < alrulfu_pkg::GHOST_SLOTS;
		u_gidx = idx_s1[alrulfu_pkg::GHOST_AW-1:0];
		s_gv   = u_gok && ghost_valid_q[u_gidx];

		u_rv    = s_rv;
		u_is_rm = rm_valid_q && (idx_s1 == rm_idx_q);
		u_rent  = res_rd_q;
		if (rm_valid_q && (res_rd_q.rec > rm_ent_q.rec))
			u_rent.rec = res_rd_q.rec - 1'b1;
		if (rm_valid_q && (res_rd_q.freq == rm_ent_q.freq) && (res_rd_q.bkt > rm_ent_q.bkt))
			u_rent.bkt = res_rd_q.bkt - 1'b1;
		u_cnt = u_rv && !u_is_rm && (res_rd_q.freq == f_tgt_q);

		u_gv     = s_gv;
		u_is_grm = gh_hit_q && (u_gidx == gh_idx_q);
		u_adj    = ghost_rd_q.stamp;
		if (gh_hit_q && (ghost_rd_q.stamp > gh_ent_q.stamp))
			u_adj = ghost_rd_q.stamp - 1'b1;
		// dropping the oldest entry shifts every other rank down by one
		u_dropping = drop_q && !drop_self_q && (u_adj == '0);
		u_gent     = ghost_rd_q;
		u_gent.stamp = (drop_q && !drop_self_q) ? u_adj - 1'b1 : u_adj;
	end

	// ---------------- memory write ports ----------------
	always_comb begin
		res_we      = 1'b0;
		res_waddr   = idx_s1;
		res_wdata   = u_rent;
		ghost_we    = 1'b0;
		ghost_waddr = u_gidx;
		ghost_wdata = u_gent;
		if (state_q == alrulfu_pkg::ST_COMMIT) begin
			res_we          = new_write_q;
			res_waddr       = new_slot_q;
			res_wdata.tag   = page_q;
			res_wdata.freq  = f_tgt_q;
			res_wdata.rec   = new_rec_q;
			res_wdata.bkt   = nt_q;
			ghost_we          = app_q;
			ghost_waddr       = gfree_idx_q;
			ghost_wdata.tag   = evict_page_q;
			ghost_wdata.lfu   = by_lfu_q;
			ghost_wdata.stamp = app_stamp_q;
		end else if (vld_s1 && pass_s1) begin
			res_we   = u_rv && !u_is_rm;
			ghost_we = u_gv && !u_is_grm && !u_dropping;
		end
	end

	always_ff @(posedge clk) begin
		if (res_we) res_mem[res_waddr] <= res_wdata;
		res_rd_q <= res_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (ghost_we) ghost_mem[ghost_waddr] <= ghost_wdata;
		ghost_rd_q <= ghost_mem[addr_q[alrulfu_pkg::GHOST_AW-1:0]];
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q   <= '0;
			ghost_valid_q <= '0;
			cap_q         <= alrulfu_pkg::CAP_W'(alrulfu_pkg::CAPACITY);
			bal_q         <= '0;
			addr_q        <= '0;
			vld_s1        <= 1'b0;
			pass_s1       <= 1'b0;
			idx_s1        <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) cap_q <= cfg_data;

			vld_s1  <= (state_q == alrulfu_pkg::ST_SCAN) || (state_q == alrulfu_pkg::ST_UPDATE);
			pass_s1 <= (state_q == alrulfu_pkg::ST_UPDATE);
			idx_s1  <= addr_q;

			if ((state_q == alrulfu_pkg::ST_SCAN) || (state_q == alrulfu_pkg::ST_UPDATE))
				addr_q <= addr_q + 1'b1;
			else
				addr_q <= '0;

			if (state_q == alrulfu_pkg::ST_DECIDE) bal_q <= d_bal;

			if (vld_s1 && pass_s1) begin
				if (u_is_rm) res_valid_q[idx_s1] <= 1'b0;
				if (u_gv && (u_is_grm || u_dropping)) ghost_valid_q[u_gidx] <= 1'b0;
			end
			if (state_q == alrulfu_pkg::ST_COMMIT) begin
				if (new_write_q) res_valid_q[new_slot_q] <= 1'b1;
				if (app_q) ghost_valid_q[gfree_idx_q] <= 1'b1;
			end

			rsp_valid_q <= (accept && req.mode) || (state_q == alrulfu_pkg::ST_COMMIT);
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q        <= req.page;
			hit_found_q   <= 1'b0;
			gh_found_q    <= 1'b0;
			rfree_found_q <= 1'b0;
			gfree_found_q <= 1'b0;
			rcount_q      <= '0;
			gcount_q      <= '0;
		end

		if (s_scan) begin
			if (s_rv) begin
				rcount_q <= rcount_q + 1'b1;
				if (!hit_found_q && (res_rd_q.tag == page_q)) begin
					hit_found_q <= 1'b1;
					hit_idx_q   <= idx_s1;
					hit_ent_q   <= res_rd_q;
				end
				if ((rcount_q == '0) || (res_rd_q.rec < lru_ent_q.rec)) begin
					lru_idx_q <= idx_s1;
					lru_ent_q <= res_rd_q;
				end
				if ((rcount_q == '0) || (res_rd_q.freq < lfu_ent_q.freq) ||
				    ((res_rd_q.freq == lfu_ent_q.freq) && (res_rd_q.bkt < lfu_ent_q.bkt))) begin
					lfu_idx_q <= idx_s1;
					lfu_ent_q <= res_rd_q;
				end
			end else if (!rfree_found_q) begin
				rfree_found_q <= 1'b1;
				rfree_idx_q   <= idx_s1;
			end
			if (s_gv) begin
				gcount_q <= gcount_q + 1'b1;
				if (!gh_found_q && (ghost_rd_q.tag == page_q)) begin
					gh_found_q <= 1'b1;
					gh_idx_q   <= u_gidx;
					gh_ent_q   <= ghost_rd_q;
				end
			end else if (u_gok && !gfree_found_q) begin
				gfree_found_q <= 1'b1;
				gfree_idx_q   <= u_gidx;
			end
		end

		if (state_q == alrulfu_pkg::ST_DECIDE) begin
			res_hit_q    <= d_res_hit;
			gh_hit_q     <= d_gh_hit;
			evict_q      <= d_evict;
			by_lfu_q     <= d_by_lfu;
			rm_valid_q   <= d_rm_valid;
			rm_idx_q     <= d_rm_idx;
			rm_ent_q     <= d_rm_ent;
			f_tgt_q      <= d_ftgt;
			new_slot_q   <= d_res_hit ? hit_idx_q : rfree_idx_q;
			new_write_q  <= d_res_hit || !(d_evict && d_victim_new);
			new_rec_q    <= alrulfu_pkg::RANK_W'(rcount_q - alrulfu_pkg::CNT_W'(d_rm_valid));
			nt_q         <= '0;
			evict_page_q <= d_evict_page;
			drop_page_q  <= d_evict_page;
			drop_q       <= d_drop;
			drop_self_q  <= d_drop_self;
			app_q        <= d_evict && !d_drop_self;
			app_stamp_q  <= alrulfu_pkg::GSTAMP_W'(d_gc_rem - alrulfu_pkg::CNT_W'(d_drop));
		end

		if (vld_s1 && pass_s1) begin
			if (u_cnt) nt_q <= nt_q + 1'b1;
			if (u_gv && !u_is_grm && u_dropping) drop_page_q <= ghost_rd_q.tag;
		end

		if (accept && req.mode) begin
			rsp_q <= alrulfu_pkg::acc_rsp_t'{outcome: alrulfu_pkg::OUT_WRITE, default: '0};
		end else if (state_q == alrulfu_pkg::ST_COMMIT) begin
			if (res_hit_q)
				rsp_q.outcome <= alrulfu_pkg::OUT_HIT;
			else if (gh_hit_q)
				rsp_q.outcome <= gh_ent_q.lfu ? alrulfu_pkg::OUT_GHOST_LFU
				                              : alrulfu_pkg::OUT_GHOST_LRU;
			else
				rsp_q.outcome <= alrulfu_pkg::OUT_MISS;
			rsp_q.evict_valid  <= evict_q;
			rsp_q.evict_page   <= evict_q ? evict_page_q : '0;
			rsp_q.evict_by_lfu <= evict_q && by_lfu_q;
			rsp_q.drop_valid   <= drop_q;
			rsp_q.drop_page    <= drop_q ? drop_page_q : '0;
		end
	end

`ifndef SYNTHESIS
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $past(state_q == alrulfu_pkg::ST_COMMIT || (start && !busy && req.mode)))
		else $error("result strobe without a finished item");

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == alrulfu_pkg::ST_IDLE |->
			$countones(res_valid_q) <= alrulfu_pkg::CAPACITY)
		else $error("resident set above capacity");

	a_ghost_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == alrulfu_pkg::ST_IDLE |->
			$countones(ghost_valid_q) < alrulfu_pkg::GHOST_SLOTS)
		else $error("ghost list has no free slot");

	a_evict_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.evict_valid |->
			rsp.outcome != alrulfu_pkg::OUT_HIT && rsp.outcome != alrulfu_pkg::OUT_WRITE)
		else $error("eviction on a hit or write");

	a_drop_needs_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.drop_valid |-> rsp.evict_valid)
		else $error("ghost drop without eviction");
`endif

endmodule
